// ===== sv/abpm_pkg.sv =====
// Shared types, constants and order tables for the aberration phase map block.
package abpm_pkg;

  // Angle constants in units of 2^-16 rad
  localparam int PI16      = 205887;
  localparam int HALF_PI16 = 102944;
  localparam int TWO_PI16  = 411775;

  // CORDIC gain compensation in Q2.30
  localparam int CORDIC_K = 652032874;

  // Radius value that marks "no radius found"
  localparam logic [16:0] NONE_RADIUS = 17'h1FFFF;

  // Divider: 48-bit dividend, four quotient bits per cycle
  localparam int DIV_NUM_W  = 48;
  localparam int DIV_DEN_W  = 13;
  localparam int DIV_BITS   = 4;
  localparam int DIV_CYCLES = DIV_NUM_W / DIV_BITS;

  // Command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] CFG_GRID_HALF_EXTENT = 3'd0;
  localparam logic [2:0] CFG_APERTURE_RADIUS  = 3'd1;
  localparam logic [2:0] CFG_PHASE_SCALE      = 3'd2;
  localparam logic [2:0] CFG_PHASE_THRESHOLD  = 3'd3;
  localparam logic [2:0] CFG_ACTIVE_TERMS     = 3'd4;

  typedef struct packed {
    logic               cmd;
    logic        [3:0]  coef_index;
    logic signed [31:0] coef_magnitude;
    logic signed [15:0] coef_angle;
    logic        [7:0]  pixel_x;
    logic        [7:0]  pixel_y;
    logic               frame_start;
  } req_word_t;

  typedef struct packed {
    logic        [16:0] radius;
    logic signed [15:0] azimuth;
    logic               aperture_pass;
    logic signed [31:0] phase;
    logic        [7:0]  phase_mask;
    logic        [16:0] min_radius;
  } res_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIVX,
    ST_DIVY,
    ST_SQX,
    ST_SQY,
    ST_SQRT,
    ST_VEC,
    ST_TERM,
    ST_REDUCE,
    ST_ROT,
    ST_MUL,
    ST_DIVT,
    ST_FINISH
  } state_t;

  // Radial order of each term
  function automatic logic [2:0] order_n(input logic [3:0] k);
    case (k)
      4'd0, 4'd1:               order_n = 3'd1;
      4'd2, 4'd3:               order_n = 3'd2;
      4'd4, 4'd5, 4'd6:         order_n = 3'd3;
      4'd7, 4'd8, 4'd9:         order_n = 3'd4;
      4'd10, 4'd11, 4'd12, 4'd13: order_n = 3'd5;
      default:                  order_n = 3'd0;
    endcase
  endfunction

  // Azimuthal order of each term
  function automatic logic [2:0] order_m(input logic [3:0] k);
    case (k)
      4'd0:    order_m = 3'd0;
      4'd1:    order_m = 3'd2;
      4'd2:    order_m = 3'd1;
      4'd3:    order_m = 3'd3;
      4'd4:    order_m = 3'd0;
      4'd5:    order_m = 3'd2;
      4'd6:    order_m = 3'd4;
      4'd7:    order_m = 3'd1;
      4'd8:    order_m = 3'd3;
      4'd9:    order_m = 3'd5;
      4'd10:   order_m = 3'd0;
      4'd11:   order_m = 3'd2;
      4'd12:   order_m = 3'd4;
      4'd13:   order_m = 3'd6;
      default: order_m = 3'd0;
    endcase
  endfunction

  // CORDIC arctangent steps in 2^-16 rad
  function automatic logic [15:0] atan_step(input logic [3:0] i);
    case (i)
      4'd0:    atan_step = 16'd51472;
      4'd1:    atan_step = 16'd30386;
      4'd2:    atan_step = 16'd16055;
      4'd3:    atan_step = 16'd8150;
      4'd4:    atan_step = 16'd4091;
      4'd5:    atan_step = 16'd2047;
      4'd6:    atan_step = 16'd1024;
      4'd7:    atan_step = 16'd512;
      4'd8:    atan_step = 16'd256;
      4'd9:    atan_step = 16'd128;
      4'd10:   atan_step = 16'd64;
      4'd11:   atan_step = 16'd32;
      4'd12:   atan_step = 16'd16;
      4'd13:   atan_step = 16'd8;
      4'd14:   atan_step = 16'd4;
      4'd15:   atan_step = 16'd2;
      default: atan_step = 16'd0;
    endcase
  endfunction

endpackage

// ===== sv/abpm_req_if.sv =====
// Request channel: command words with valid and ready.
interface abpm_req_if;
  logic                valid;
  logic                ready;
  abpm_pkg::req_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== sv/abpm_res_if.sv =====
// Result channel: pixel result words with valid and ready.
interface abpm_res_if;
  logic                valid;
  logic                ready;
  abpm_pkg::res_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== sv/aberration_phase_map.sv =====
// Aberration phase map: polar mapping and per-pixel phase sum over a shared datapath.
//
//  channel   dir  handshake            word
//  request   in   valid/ready          req_word_t (load or pixel command)
//  result    out  valid/ready          res_word_t (one per pixel command)
//  cfg       in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A load writes the coefficient table directly. A pixel runs the grid divides,
// the square root and the vectoring, then per term the angle reduce steps, the
// rotation, the multiplies and a divide, on the shared 48x16 multiplier and the
// 4-bit-per-cycle divider.
// Reset is synchronous; the coefficient table clears to zero at once.
// A finished result waits in the output register; a new pixel may start, and
// holds in its last step until the previous word has been taken.
module aberration_phase_map #(
  parameter int GRID_SIZE  = 256,
  parameter int TERM_COUNT = 14
) (
  input  logic              clk,
  input  logic              rst,
  abpm_req_if.sink          request,
  abpm_res_if.source        result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import abpm_pkg::*;

  localparam int HALF  = GRID_SIZE / 2;
  localparam int IDX_W = (TERM_COUNT > 1) ? $clog2(TERM_COUNT) : 1;
  localparam logic [12:0] PIX_LAST  = 13'(GRID_SIZE - 1);
  localparam logic [13:0] HALF_C    = 14'(HALF);
  localparam logic [3:0]  TERMS_MAX = 4'(TERM_COUNT);
  localparam logic [47:0] SAT_CAP   = 48'h8000_0000_0000;

  // Configuration registers
  logic [15:0] grid_half_extent;
  logic [16:0] aperture_radius;
  logic [31:0] phase_scale;
  logic [30:0] phase_threshold;
  logic [3:0]  active_terms;

  // Coefficient table and running minimum
  logic [31:0] coef_magnitudes [TERM_COUNT];
  logic [15:0] coef_angles     [TERM_COUNT];
  logic [16:0] running_min_radius;

  state_t state, state_next;

  // Datapath registers
  logic [12:0]        pix_row;
  logic               x_neg, y_neg;
  logic [15:0]        xq, yq;
  logic [35:0]        sq_v, sq_res, sq_bit;
  logic [16:0]        radius;
  logic signed [15:0] az;
  logic signed [33:0] cx, cy;
  logic signed [23:0] cz;
  logic [3:0]         ci;
  logic [3:0]         k;
  logic               cm_neg, cneg;
  logic [32:0]        cm_abs;
  logic [16:0]        cv;
  logic [47:0]        pw, tv;
  logic [2:0]         mstep;
  logic [1:0]         mdig;
  logic [95:0]        acc;
  logic signed [52:0] sum;
  logic [47:0]        div_num;
  logic [12:0]        div_den, div_rem;
  logic [3:0]         div_cnt;
  logic               res_valid;
  res_word_t          res_word;

  // Handshake decode
  logic req_fire, res_fire, out_free;
  assign request.ready = (state == ST_IDLE);
  assign req_fire      = request.valid && request.ready;
  assign res_fire      = res_valid && result.ready;
  assign out_free      = !res_valid || result.ready;
  assign cfg_ready     = 1'b1;
  assign result.valid  = res_valid;
  assign result.data   = res_word;

  // Term orders and effective count
  logic [2:0] n_cur, m_cur;
  logic [3:0] terms_eff;
  assign n_cur     = order_n(k);
  assign m_cur     = order_m(k);
  assign terms_eff = (active_terms > TERMS_MAX) ? TERMS_MAX : active_terms;

  // Grid offset magnitude times half extent
  logic [12:0]        pix_sel;
  logic [12:0]        pix_clamp;
  logic [12:0]        pix_x_clamp;
  logic signed [13:0] grid_d;
  logic [11:0]        grid_dmag;
  logic [27:0]        grid_prod;
  assign pix_x_clamp = (13'(request.data.pixel_x) > PIX_LAST) ? PIX_LAST
                                                             : 13'(request.data.pixel_x);
  always_comb begin
    pix_sel   = (state == ST_IDLE) ? pix_x_clamp : pix_row;
    grid_d    = $signed({1'b0, pix_sel}) - $signed(HALF_C);
    grid_dmag = grid_d[13] ? 12'(-grid_d) : grid_d[11:0];
    grid_prod = grid_dmag * grid_half_extent;
  end
  assign pix_clamp = (13'(request.data.pixel_y) > PIX_LAST) ? PIX_LAST
                                                           : 13'(request.data.pixel_y);

  // Divider step: four restoring steps per cycle
  logic [47:0] div_num_next;
  logic [12:0] div_rem_next;
  logic [13:0] dv_rem;
  logic        div_last;
  always_comb begin
    dv_rem       = {1'b0, div_rem};
    div_num_next = div_num;
    for (int b = 0; b < DIV_BITS; b++) begin
      dv_rem       = {dv_rem[12:0], div_num_next[47]};
      div_num_next = {div_num_next[46:0], 1'b0};
      if (dv_rem >= {1'b0, div_den}) begin
        dv_rem          = dv_rem - {1'b0, div_den};
        div_num_next[0] = 1'b1;
      end
    end
    div_rem_next = dv_rem[12:0];
  end
  assign div_last = (div_cnt == 4'(DIV_CYCLES - 1));

  // Squares of the coordinates
  logic [15:0] sq_op;
  logic [31:0] sq_prod;
  assign sq_op   = (state == ST_SQX) ? xq : yq;
  assign sq_prod = sq_op * sq_op;

  // Integer square root step
  logic [35:0] sq_try;
  assign sq_try = sq_res + sq_bit;

  // Vectoring start values
  logic signed [17:0] xs, ys;
  logic signed [33:0] vx0, vy0;
  assign xs  = x_neg ? -$signed({2'b0, xq}) : $signed({2'b0, xq});
  assign ys  = y_neg ? -$signed({2'b0, yq}) : $signed({2'b0, yq});
  assign vx0 = 34'(xs) <<< 12;
  assign vy0 = 34'(ys) <<< 12;

  // Shared CORDIC step
  logic signed [33:0] cx_sh, cy_sh, cx_next, cy_next;
  logic signed [23:0] cz_next, at_w;
  always_comb begin
    cx_sh   = cx >>> ci;
    cy_sh   = cy >>> ci;
    at_w    = $signed({8'd0, atan_step(ci)});
    cx_next = cx;
    cy_next = cy;
    cz_next = cz;
    if (state == ST_VEC) begin
      if (cy > 0) begin
        cx_next = cx + cy_sh;
        cy_next = cy - cx_sh;
        cz_next = cz + at_w;
      end else if (cy < 0) begin
        cx_next = cx - cy_sh;
        cy_next = cy + cx_sh;
        cz_next = cz - at_w;
      end
    end else begin
      if (cz >= 0) begin
        cx_next = cx - cy_sh;
        cy_next = cy + cx_sh;
        cz_next = cz - at_w;
      end else begin
        cx_next = cx + cy_sh;
        cy_next = cy - cx_sh;
        cz_next = cz + at_w;
      end
    end
  end

  // Azimuth rounding and cosine rounding
  logic signed [23:0] az_wide;
  logic signed [15:0] az_next;
  logic signed [33:0] cos_wide;
  logic [16:0]        cv_next;
  always_comb begin
    az_wide = (cz_next + 24'sd4) >>> 3;
    if (az_wide > 24'sd32767)       az_next = 16'sh7FFF;
    else if (az_wide < -24'sd32768) az_next = -16'sh8000;
    else                            az_next = az_wide[15:0];
    cos_wide = (cx_next + 34'sd8192) >>> 14;
    if (cos_wide < 0)                cv_next = 17'd0;
    else if (cos_wide > 34'sd65536)  cv_next = 17'd65536;
    else                             cv_next = cos_wide[16:0];
  end

  // Term angle and coefficient magnitude
  logic signed [23:0] ang_raw, diff_w;
  logic signed [32:0] cm_w;
  logic [31:0]        cm_sel;
  logic [15:0]        ca_sel;
  always_comb begin
    cm_sel  = coef_magnitudes[k[IDX_W-1:0]];
    ca_sel  = coef_angles[k[IDX_W-1:0]];
    diff_w  = 24'(az) - 24'($signed(ca_sel));
    ang_raw = (diff_w * $signed({21'd0, m_cur})) <<< 3;
    cm_w    = $signed({cm_sel[31], cm_sel});
  end

  // Angle fold into the right half plane
  logic signed [23:0] fold_a, fold_r;
  logic               fold_neg;
  always_comb begin
    fold_a   = (cz > 24'(PI16)) ? cz - 24'(TWO_PI16) : cz;
    fold_neg = 1'b0;
    fold_r   = fold_a;
    if (fold_a > 24'(HALF_PI16)) begin
      fold_r   = 24'(PI16) - fold_a;
      fold_neg = 1'b1;
    end else if (fold_a < -24'(HALF_PI16)) begin
      fold_r   = -24'(PI16) - fold_a;
      fold_neg = 1'b1;
    end
  end

  // Shared multiplier: 48x16 per cycle, saturating Q16.16 result
  logic [47:0] mul_a, mul_b;
  logic [15:0] mul_d;
  logic [63:0] mul_pp;
  logic [95:0] acc_next;
  logic [47:0] mul_res;
  always_comb begin
    if (mstep < n_cur) begin
      mul_a = pw;
      mul_b = {23'd0, radius, 8'd0};
    end else if (mstep == n_cur) begin
      mul_a = {16'd0, phase_scale};
      mul_b = {15'd0, cm_abs};
    end else if (mstep == 3'(n_cur + 3'd1)) begin
      mul_a = tv;
      mul_b = pw;
    end else begin
      mul_a = tv;
      mul_b = {31'd0, cv};
    end
    case (mdig)
      2'd0:    mul_d = mul_b[15:0];
      2'd1:    mul_d = mul_b[31:16];
      default: mul_d = mul_b[47:32];
    endcase
    mul_pp   = mul_a * mul_d;
    acc_next = ((mdig == 2'd0) ? 96'd0 : acc) + (96'(mul_pp) << {mdig, 4'd0});
    mul_res  = (|acc_next[95:63]) ? SAT_CAP : {1'b0, acc_next[62:16]};
  end

  // Final phase, mask and running minimum
  logic signed [31:0] phase_sat;
  logic [32:0]        phase_mag;
  logic [16:0]        run_next;
  always_comb begin
    if (sum > 53'sd2147483647)       phase_sat = 32'sh7FFF_FFFF;
    else if (sum < -53'sd2147483648) phase_sat = 32'sh8000_0000;
    else                             phase_sat = sum[31:0];
    phase_mag = phase_sat[31] ? 33'(-$signed({phase_sat[31], phase_sat}))
                              : {1'b0, phase_sat};
    run_next = running_min_radius;
    if (phase_mag > {2'b0, phase_threshold} && radius != 17'd0 &&
        radius < running_min_radius)
      run_next = radius;
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (req_fire && request.data.cmd == CMD_PIXEL) state_next = ST_DIVX;
      ST_DIVX:   if (div_last) state_next = ST_DIVY;
      ST_DIVY:   if (div_last) state_next = ST_SQX;
      ST_SQX:    state_next = ST_SQY;
      ST_SQY:    state_next = ST_SQRT;
      ST_SQRT:   if (sq_bit[0]) state_next = ST_VEC;
      ST_VEC:    if (ci == 4'd15) state_next = ST_TERM;
      ST_TERM:   state_next = (k >= terms_eff) ? ST_FINISH : ST_REDUCE;
      ST_REDUCE: if (cz >= 0 && cz < 24'(TWO_PI16)) state_next = ST_ROT;
      ST_ROT:    if (ci == 4'd15) state_next = ST_MUL;
      ST_MUL:    if (mdig == 2'd2 && mstep == 3'(n_cur + 3'd2)) state_next = ST_DIVT;
      ST_DIVT:   if (div_last) state_next = ST_TERM;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_half_extent <= 16'd5120;
      aperture_radius  <= 17'd7680;
      phase_scale      <= 32'd65536;
      phase_threshold  <= 31'd51472;
      active_terms     <= 4'd14;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GRID_HALF_EXTENT: grid_half_extent <= cfg_data[15:0];
        CFG_APERTURE_RADIUS:  aperture_radius  <= cfg_data[16:0];
        CFG_PHASE_SCALE:      phase_scale      <= cfg_data;
        CFG_PHASE_THRESHOLD:  phase_threshold  <= cfg_data[30:0];
        CFG_ACTIVE_TERMS:     active_terms     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Coefficient loads
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int e = 0; e < TERM_COUNT; e++) begin
        coef_magnitudes[e] <= 32'd0;
        coef_angles[e]     <= 16'd0;
      end
    end else if (req_fire && request.data.cmd == CMD_LOAD &&
                 request.data.coef_index < TERMS_MAX) begin
      coef_magnitudes[request.data.coef_index[IDX_W-1:0]] <= request.data.coef_magnitude;
      coef_angles[request.data.coef_index[IDX_W-1:0]]     <= request.data.coef_angle;
    end
  end

  // Running minimum and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      running_min_radius <= NONE_RADIUS;
      res_valid          <= 1'b0;
    end else begin
      if (res_fire) res_valid <= 1'b0;
      if (req_fire && request.data.cmd == CMD_PIXEL && request.data.frame_start)
        running_min_radius <= NONE_RADIUS;
      if (state == ST_FINISH && out_free) begin
        running_min_radius <= run_next;
        res_valid          <= 1'b1;
      end
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      res_word.radius        <= radius;
      res_word.azimuth       <= az;
      res_word.aperture_pass <= (radius <= aperture_radius);
      res_word.phase         <= phase_sat;
      res_word.phase_mask    <= (phase_mag <= {2'b0, phase_threshold}) ? 8'd255 : 8'd0;
      res_word.min_radius    <= run_next;
    end
  end

  // Datapath sequencing
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req_fire && request.data.cmd == CMD_PIXEL) begin
          pix_row <= pix_clamp;
          x_neg   <= grid_d[13];
          div_num <= 48'(grid_prod);
          div_den <= 13'(HALF);
          div_rem <= '0;
          div_cnt <= '0;
          sum     <= '0;
          k       <= '0;
        end
      end
      ST_DIVX, ST_DIVY: begin
        div_num <= div_num_next;
        div_rem <= div_rem_next;
        div_cnt <= div_cnt + 4'd1;
        if (div_last) begin
          if (state == ST_DIVX) begin
            xq      <= div_num_next[15:0];
            y_neg   <= grid_d[13];
            div_num <= 48'(grid_prod);
            div_rem <= '0;
            div_cnt <= '0;
          end else begin
            yq <= div_num_next[15:0];
          end
        end
      end
      ST_SQX: sq_v <= 36'(sq_prod);
      ST_SQY: begin
        sq_v   <= sq_v + 36'(sq_prod);
        sq_res <= '0;
        sq_bit <= 36'h4_0000_0000;
      end
      ST_SQRT: begin
        if (sq_v >= sq_try) begin
          sq_v   <= sq_v - sq_try;
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
        if (sq_bit[0]) begin
          if (sq_v >= sq_try)
            radius <= (((sq_res >> 1) + sq_bit) > 36'(NONE_RADIUS)) ? NONE_RADIUS
                      : sq_res[17:1] + 17'd1;
          else
            radius <= ((sq_res >> 1) > 36'(NONE_RADIUS)) ? NONE_RADIUS : sq_res[17:1];
          ci <= '0;
          if (vx0 < 0) begin
            cx <= -vx0;
            cy <= -vy0;
            cz <= (vy0 >= 0) ? 24'(PI16) : -24'(PI16);
          end else begin
            cx <= vx0;
            cy <= vy0;
            cz <= '0;
          end
        end
      end
      ST_VEC: begin
        cx <= cx_next;
        cy <= cy_next;
        cz <= cz_next;
        ci <= ci + 4'd1;
        if (ci == 4'd15) az <= az_next;
      end
      ST_TERM: begin
        cz     <= ang_raw;
        cm_neg <= cm_sel[31];
        cm_abs <= cm_sel[31] ? 33'(-cm_w) : 33'(cm_w);
      end
      ST_REDUCE: begin
        if (cz < 0) begin
          cz <= cz + 24'(TWO_PI16);
        end else if (cz >= 24'(TWO_PI16)) begin
          cz <= cz - 24'(TWO_PI16);
        end else begin
          cz   <= fold_r;
          cneg <= fold_neg;
          cx   <= 34'(CORDIC_K);
          cy   <= '0;
          ci   <= '0;
        end
      end
      ST_ROT: begin
        cx <= cx_next;
        cy <= cy_next;
        cz <= cz_next;
        ci <= ci + 4'd1;
        if (ci == 4'd15) begin
          cv    <= cv_next;
          pw    <= {23'd0, radius, 8'd0};
          mstep <= '0;
          mdig  <= '0;
        end
      end
      ST_MUL: begin
        acc <= acc_next;
        if (mdig == 2'd2) begin
          mdig  <= '0;
          mstep <= mstep + 3'd1;
          if (mstep < n_cur)                   pw <= mul_res;
          else                                 tv <= mul_res;
          if (mstep == 3'(n_cur + 3'd2)) begin
            div_num <= mul_res;
            div_den <= 13'(n_cur) + 13'd1;
            div_rem <= '0;
            div_cnt <= '0;
          end
        end else begin
          mdig <= mdig + 2'd1;
        end
      end
      ST_DIVT: begin
        div_num <= div_num_next;
        div_rem <= div_rem_next;
        div_cnt <= div_cnt + 4'd1;
        if (div_last) begin
          if (cm_neg != cneg) sum <= sum - $signed({5'd0, div_num_next});
          else                sum <= sum + $signed({5'd0, div_num_next});
          k <= k + 4'd1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the aberration phase map block.
module testbench;
  import abpm_pkg::*;

  localparam longint unsigned SAT_CAP = 64'd1 << 47;
  localparam int NUM_TERMS = 14;

  logic clk;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  abpm_req_if req_if();
  abpm_res_if res_if();

  aberration_phase_map DUT (
    .clk(clk),
    .rst(rst),
    .request(req_if.sink),
    .result(res_if.source),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Predictor state
  longint grid_extent, aper_radius, scale_q16, thresh_q16, term_limit;
  longint coef_mag [NUM_TERMS];
  longint coef_ang [NUM_TERMS];
  longint min_seen_radius;

  res_word_t phase_results_q[$];
  int fail_count;
  int words_sent;
  int pixels_checked;
  int loads_sent;
  int cfg_writes;
  bit idle_on;
  bit hold_request;
  int hold_left;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard limit on run length
  initial begin
    #60000000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int radial_order(int k);
    if (k < 2) return 1;
    if (k < 4) return 2;
    if (k < 7) return 3;
    if (k < 10) return 4;
    return 5;
  endfunction

  function automatic int azimuth_order(int k);
    case (k)
      1, 5, 11: return 2;
      2, 7:     return 1;
      3, 8:     return 3;
      6, 12:    return 4;
      9:        return 5;
      13:       return 6;
      default:  return 0;
    endcase
  endfunction

  function automatic longint arctan_step(int i);
    case (i)
      0: return 51472;  1: return 30386;  2: return 16055;  3: return 8150;
      4: return 4091;   5: return 2047;   6: return 1024;   7: return 512;
      8: return 256;    9: return 128;    10: return 64;    11: return 32;
      12: return 16;    13: return 8;     14: return 4;     default: return 2;
    endcase
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Q16.16 product, saturating
  function automatic longint unsigned sat_mul(longint unsigned a, longint unsigned b);
    longint unsigned p;
    if (a == 0 || b == 0) return 0;
    if (a > 64'hFFFF_FFFF_FFFF_FFFF / b) return SAT_CAP;
    p = (a * b) >> 16;
    return (p > SAT_CAP) ? SAT_CAP : p;
  endfunction

  // Vectoring CORDIC: pixel azimuth in Q3.13
  function automatic longint polar_angle(longint x, longint y);
    longint z, q, nx, ny;
    int i;
    z = 0;
    if (x == 0 && y == 0) return 0;
    x = x * 4096;
    y = y * 4096;
    if (x < 0) begin
      z = (y >= 0) ? PI16 : -PI16;
      x = -x;
      y = -y;
    end
    for (i = 0; i < 16 && y != 0; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); z = z + arctan_step(i);
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); z = z - arctan_step(i);
      end
      x = nx;
      y = ny;
    end
    q = (z + 4) >>> 3;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q;
  endfunction

  // Rotation CORDIC: cosine magnitude in Q1.16, sign through neg
  function automatic longint unsigned cos_magnitude(longint a, output bit neg);
    longint r, x, y, c, nx, ny;
    int i;
    r = a % TWO_PI16;
    x = CORDIC_K;
    y = 0;
    if (r < 0) r = r + TWO_PI16;
    if (r > PI16) r = r - TWO_PI16;
    neg = 1'b0;
    if (r > HALF_PI16) begin
      r = PI16 - r; neg = 1'b1;
    end else if (r < -HALF_PI16) begin
      r = -PI16 - r; neg = 1'b1;
    end
    for (i = 0; i < 16; i++) begin
      if (r >= 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); r = r - arctan_step(i);
      end else begin
        nx = x + (y >>> i); ny = y - (x >>> i); r = r + arctan_step(i);
      end
      x = nx;
      y = ny;
    end
    c = (x + 8192) >>> 14;
    if (c < 0) c = 0;
    if (c > 65536) c = 65536;
    return c;
  endfunction

  function automatic longint grid_position(longint p);
    return ((p - 128) * grid_extent) / 128;
  endfunction

  // Update predictor with one accepted word; queue the expected pixel result
  function automatic void predict_phase(req_word_t w);
    longint x, y, az, sum, mag, cm, ca;
    longint unsigned radius, r16, pw, t, cv;
    int terms, k, j, n;
    bit cneg, neg;
    res_word_t e;
    if (w.cmd == CMD_LOAD) begin
      if (w.coef_index < NUM_TERMS) begin
        coef_mag[w.coef_index] = w.coef_magnitude;
        coef_ang[w.coef_index] = w.coef_angle;
      end
      return;
    end
    if (w.frame_start) min_seen_radius = NONE_RADIUS;
    x = grid_position(w.pixel_x);
    y = grid_position(w.pixel_y);
    radius = int_sqrt(x * x + y * y);
    if (radius > NONE_RADIUS) radius = NONE_RADIUS;
    az = polar_angle(x, y);
    r16 = radius << 8;
    terms = (term_limit > NUM_TERMS) ? NUM_TERMS : term_limit;
    sum = 0;
    for (k = 0; k < terms; k++) begin
      cm = coef_mag[k];
      ca = coef_ang[k];
      n = radial_order(k);
      neg = cm < 0;
      pw = r16;
      for (j = 0; j < n; j++) pw = sat_mul(pw, r16);
      t = sat_mul(scale_q16, neg ? -cm : cm);
      t = sat_mul(t, pw);
      cv = cos_magnitude(azimuth_order(k) * (az - ca) * 8, cneg);
      t = (t * cv) >> 16;
      t = t / (n + 1);
      if (neg != cneg) sum = sum - longint'(t);
      else sum = sum + longint'(t);
    end
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    mag = (sum < 0) ? -sum : sum;
    if (mag > thresh_q16 && radius > 0 && radius < min_seen_radius)
      min_seen_radius = radius;
    e.radius = radius[16:0];
    e.azimuth = az[15:0];
    e.aperture_pass = (radius <= aper_radius);
    e.phase = sum[31:0];
    e.phase_mask = (mag <= thresh_q16) ? 8'd255 : 8'd0;
    e.min_radius = min_seen_radius[16:0];
    phase_results_q.push_back(e);
  endfunction

  function automatic void compare_field(string name, longint e, longint a);
    if (e != a) begin
      fail_count++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, e, a);
    end
  endfunction

  // Check each result word at the negedge before its handshake edge
  always @(negedge clk) begin
    res_word_t e;
    if (!rst && res_if.valid && res_if.ready) begin
      if (phase_results_q.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result word, actual phase %0d", $time,
                 res_if.data.phase);
      end else begin
        e = phase_results_q.pop_front();
        pixels_checked++;
        compare_field("radius", e.radius, res_if.data.radius);
        compare_field("azimuth", e.azimuth, res_if.data.azimuth);
        compare_field("aperture_pass", e.aperture_pass, res_if.data.aperture_pass);
        compare_field("phase", e.phase, res_if.data.phase);
        compare_field("phase_mask", e.phase_mask, res_if.data.phase_mask);
        compare_field("min_radius", e.min_radius, res_if.data.min_radius);
      end
    end
  end

  // Drive result ready: random stalls plus long holds on request
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = 2500;
      res_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= !idle_on || ($urandom_range(99) >= 35);
    end
  end

  // Send one request word, idling at random first
  task automatic send_word(req_word_t w);
    bit got;
    if (idle_on && $urandom_range(99) < 35) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data <= w;
    do begin
      @(negedge clk);
      got = req_if.ready;
      @(posedge clk);
    end while (!got);
    predict_phase(w);
    words_sent++;
    if (w.cmd == CMD_LOAD) loads_sent++;
  endtask

  task automatic end_burst();
    req_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Hold the sender until every pixel result is back
  task automatic drain_results();
    end_burst();
    while (phase_results_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [31:0] val);
    bit got;
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      got = cfg_ready;
      @(posedge clk);
    end while (!got);
    cfg_valid <= 1'b0;
    cfg_writes++;
    case (idx)
      CFG_GRID_HALF_EXTENT: grid_extent = val[15:0];
      CFG_APERTURE_RADIUS:  aper_radius = val[16:0];
      CFG_PHASE_SCALE:      scale_q16 = val;
      CFG_PHASE_THRESHOLD:  thresh_q16 = val[30:0];
      CFG_ACTIVE_TERMS:     term_limit = val[3:0];
      default: ;
    endcase
  endtask

  task automatic write_all_cfg(logic [15:0] ext, logic [16:0] ap, logic [31:0] sc,
                               logic [30:0] th, logic [3:0] nt);
    write_cfg(CFG_GRID_HALF_EXTENT, ext);
    write_cfg(CFG_APERTURE_RADIUS, ap);
    write_cfg(CFG_PHASE_SCALE, sc);
    write_cfg(CFG_PHASE_THRESHOLD, th);
    write_cfg(CFG_ACTIVE_TERMS, nt);
  endtask

  task automatic send_load(logic [3:0] idx, logic [31:0] m, logic [15:0] a, bit fs);
    req_word_t w;
    w = '0;
    w.cmd = CMD_LOAD;
    w.coef_index = idx;
    w.coef_magnitude = m;
    w.coef_angle = a;
    w.pixel_x = $urandom;
    w.pixel_y = $urandom;
    w.frame_start = fs;
    send_word(w);
  endtask

  task automatic send_pixel(logic [7:0] px, logic [7:0] py, bit fs);
    req_word_t w;
    w.cmd = CMD_PIXEL;
    w.coef_index = $urandom;
    w.coef_magnitude = $urandom;
    w.coef_angle = $urandom;
    w.pixel_x = px;
    w.pixel_y = py;
    w.frame_start = fs;
    send_word(w);
  endtask

  task automatic send_random_word(int load_pct);
    if ($urandom_range(99) < load_pct)
      send_load($urandom_range(15), $urandom, $urandom, $urandom_range(1));
    else
      send_pixel($urandom, $urandom, $urandom_range(99) < 10);
  endtask

  // Directed: reset settings, field extremes, ignored loads, frame start
  task automatic test_directed();
    send_pixel(8'd128, 8'd128, 1'b1);
    send_pixel(8'd0, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 1'b0);
    send_load(4'd0, 32'h7FFF_FFFF, 16'h7FFF, 1'b1);
    send_load(4'd13, 32'h8000_0000, 16'h8000, 1'b0);
    send_load(4'd14, 32'h1234_5678, 16'h0100, 1'b0);
    send_load(4'd15, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    send_load(4'd1, 32'h0001_0000, 16'h0000, 1'b0);
    send_load(4'd6, 32'hFFFF_0000, 16'h1922, 1'b0);
    send_pixel(8'd0, 8'd128, 1'b0);
    send_pixel(8'd255, 8'd128, 1'b0);
    send_pixel(8'd128, 8'd0, 1'b0);
    send_pixel(8'd128, 8'd255, 1'b0);
    send_pixel(8'd0, 8'd255, 1'b1);
    send_pixel(8'd255, 8'd0, 1'b0);
    send_pixel(8'd129, 8'd127, 1'b0);
    send_pixel(8'd127, 8'd129, 1'b0);
    send_load(4'd13, 32'h0000_0000, 16'h0000, 1'b0);
    send_load(4'd0, 32'h0000_0001, 16'h0000, 1'b0);
    send_pixel(8'd200, 8'd60, 1'b0);
    drain_results();
  endtask

  // Sweep settings through their extremes
  task automatic test_cfg_extremes();
    int s, i;
    for (s = 0; s < 5; s++) begin
      case (s)
        0: write_all_cfg(16'd0, 17'd0, 32'd0, 31'd0, 4'd0);
        1: write_all_cfg(16'hFFFF, 17'h1FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 4'd15);
        2: write_all_cfg(16'hFFFF, 17'd100, 32'hFFFF_FFFF, 31'd0, 4'd3);
        3: write_all_cfg(16'd256, 17'd300, 32'd1, 31'd1, 4'd2);
        default: write_all_cfg(16'd5120, 17'd7680, 32'd65536, 31'd51472, 4'd5);
      endcase
      for (i = 0; i < 3; i++) send_load($urandom_range(13), $urandom, $urandom, 1'b0);
      for (i = 0; i < 7; i++) send_random_word(10);
    end
  endtask

  // Long receiver hold while the sender keeps offering pixels
  task automatic test_backpressure();
    int i;
    write_all_cfg($urandom_range(8000), $urandom_range(20000), $urandom, $urandom, 4'd1);
    idle_on = 1'b0;
    hold_request = 1'b1;
    for (i = 0; i < 20; i++) send_pixel($urandom, $urandom, i == 0);
    idle_on = 1'b1;
    drain_results();
  endtask

  // Random phases: random settings, mostly pixels with fresh coefficients
  task automatic test_random();
    int p, i, nt;
    for (p = 0; p < 9; p++) begin
      nt = ($urandom_range(5) == 0) ? $urandom_range(15) : $urandom_range(4);
      write_all_cfg($urandom_range(3) == 0 ? $urandom : $urandom_range(6000),
                    $urandom_range(131071) >> $urandom_range(6),
                    $urandom >> $urandom_range(20),
                    $urandom >> $urandom_range(1, 20), nt);
      idle_on = (p != 4);
      for (i = 0; i < 50; i++) send_random_word(15);
    end
    idle_on = 1'b1;
    drain_results();
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    idle_on = 1'b1;
    hold_request = 1'b0;
    hold_left = 0;
    fail_count = 0;
    words_sent = 0;
    pixels_checked = 0;
    loads_sent = 0;
    cfg_writes = 0;
    grid_extent = 5120;
    aper_radius = 7680;
    scale_q16 = 65536;
    thresh_q16 = 51472;
    term_limit = 14;
    min_seen_radius = NONE_RADIUS;
    foreach (coef_mag[k]) begin
      coef_mag[k] = 0;
      coef_ang[k] = 0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_cfg_extremes();
    test_backpressure();
    test_random();

    drain_results();
    repeat (200) @(posedge clk);
    $display("Covered %0d words (%0d loads), %0d pixel results checked, %0d register writes.",
             words_sent, loads_sent, pixels_checked, cfg_writes);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
